FILE: rtl/als_pkg.sv
// Shared types and constants for the address lease server.
// Used by als_ctrl, als_dpath and address_lease_server; no dependencies.
`default_nettype none

package als_pkg;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_PENDING  = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;
    localparam logic [1:0] ST_STALE    = 2'd3;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_OFFER = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_NAK   = 2'd3;

    localparam logic [1:0] DEST_BCAST = 2'd0;
    localparam logic [1:0] DEST_SELF  = 2'd1;
    localparam logic [1:0] DEST_OTHER = 2'd2;

    localparam logic [1:0] ACT_DISCOVER = 2'd0;
    localparam logic [1:0] ACT_REQUEST  = 2'd1;

    localparam logic [1:0] REG_POOL_SIZE     = 2'd0;
    localparam logic [1:0] REG_DEFAULT_LEASE = 2'd1;
    localparam logic [1:0] REG_MAX_LEASE     = 2'd2;
    localparam logic [1:0] REG_MIN_LEASE     = 2'd3;

    typedef struct packed {
        logic [31:0] msg_time;
        logic [15:0] client_id;
        logic [1:0]  addressed_to;
        logic [1:0]  action;
        logic [15:0] requested_addr;
        logic [31:0] requested_expiry;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [15:0] reply_client;
        logic [15:0] reply_addr;
        logic [31:0] reply_expiry;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] owner;
        logic [31:0] expiry;
    } entry_t;

    typedef struct packed {
        logic latch;
        logic grant_a;
        logic grant_b;
        logic grant_c;
        logic clear_run;
        logic sweep_run;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic sweep_done;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/als_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module als_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
    output logic      [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/als_ctrl.sv
// Sequencer for the address lease server: clear, grant, sweep, finish.
// Depends on als_pkg.
`default_nettype none

module als_ctrl
    import als_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_GRANT_A,
        S_GRANT_B,
        S_GRANT_C,
        S_SWEEP,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_run = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_GRANT_A;
                end
            end
            S_GRANT_A:
            begin
                cmd.grant_a = 1'b1;
                state_next  = S_GRANT_B;
            end
            S_GRANT_B:
            begin
                cmd.grant_b = 1'b1;
                state_next  = S_GRANT_C;
            end
            S_GRANT_C:
            begin
                cmd.grant_c = 1'b1;
                state_next  = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.sweep_run = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished item did not reach the output register");

    a_accept_starts_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == S_GRANT_A)
        else $error("accepted beat did not start the grant sequence");
`endif

endmodule

`default_nettype wire

FILE: rtl/als_dpath.sv
// Datapath for the address lease server: lease table RAM, sweep/search pass,
// lease clamp arithmetic and output payload register. Depends on als_pkg, als_ram.
`default_nettype none

module als_dpath
    import als_pkg::*;
#(
    parameter int POOL_DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    input  wire in_item_t    in_data,
    output out_item_t        out_data,
    input  wire logic [10:0] pool_size,
    input  wire logic [31:0] default_lease,
    input  wire logic [31:0] max_lease,
    input  wire logic [31:0] min_lease
);

    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int NW    = (CNT_W > 11) ? CNT_W : 11;
    localparam int EW    = $bits(entry_t);

    in_item_t        item_reg;
    out_item_t       out_reg;
    logic [NW-1:0]   n;
    logic [IDX_W-1:0] clr_cnt_reg;

    // lease clamp pipeline
    logic [31:0] d_reg;
    logic        lt_reg;
    logic [31:0] addend_reg;
    logic        use_req_reg;
    logic [31:0] grant_reg;
    logic [32:0] grant_sum;

    // sweep pipeline
    logic [NW-1:0]    rd_cnt_reg;
    logic             p_valid_reg;
    logic [IDX_W-1:0] p_idx_reg;
    entry_t           rd_entry;
    entry_t           sw_entry;
    logic             exp_hit;
    logic [EW-1:0]    rdata;

    // search results
    logic             own_f_reg, free_f_reg, stale_f_reg, pend_f_reg;
    logic [IDX_W-1:0] own_i_reg, free_i_reg, stale_i_reg, pend_i_reg;
    logic [1:0]       cap_st_reg;
    logic [15:0]      cap_own_reg;
    logic [15:0]      addr_m1;
    logic             in_range;
    logic             cap_hit;

    // write port
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;

    // finish
    logic             is_disc, is_req, is_rel, req_ok, found;
    logic [IDX_W-1:0] pick;
    out_item_t        reply;

    assign n = (NW'(pool_size) > NW'(POOL_DEPTH)) ? NW'(POOL_DEPTH) : NW'(pool_size);

    assign addr_m1  = item_reg.requested_addr - 16'd1;
    assign in_range = (item_reg.requested_addr != 16'd0)
                   && (item_reg.requested_addr <= 16'(n));

    assign rd_entry = entry_t'(rdata);
    assign exp_hit  = (item_reg.msg_time >= rd_entry.expiry);

    // expire one entry
    always_comb
    begin
        sw_entry = rd_entry;
        if (rd_entry.status == ST_OCCUPIED && exp_hit)
        begin
            sw_entry.status = ST_STALE;
            sw_entry.expiry = '0;
        end
        else if (rd_entry.status == ST_PENDING && exp_hit)
        begin
            sw_entry = '0;
        end
    end

    assign cap_hit = p_valid_reg && in_range && (16'(p_idx_reg) == addr_m1);

    assign grant_sum = {1'b0, item_reg.msg_time} + {1'b0, addend_reg};

    als_ram #(
        .WIDTH(EW),
        .DEPTH(POOL_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(EW'(wdata)),
        .raddr(rd_cnt_reg[IDX_W-1:0]),
        .rdata(rdata)
    );

    // reply and final table write
    always_comb
    begin
        is_disc = (item_reg.action == ACT_DISCOVER) && (item_reg.addressed_to == DEST_BCAST);
        is_req  = (item_reg.action == ACT_REQUEST) && (item_reg.addressed_to == DEST_SELF);
        is_rel  = (item_reg.action == ACT_REQUEST) && (item_reg.addressed_to >= DEST_OTHER);
        req_ok  = in_range && (cap_st_reg != ST_FREE) && (cap_own_reg == item_reg.client_id);
        found   = own_f_reg || free_f_reg || stale_f_reg;
        pick    = own_f_reg ? own_i_reg : (free_f_reg ? free_i_reg : stale_i_reg);
        reply   = '0;
        if (is_disc)
        begin
            if (found)
            begin
                reply.reply_kind   = KIND_OFFER;
                reply.reply_client = item_reg.client_id;
                reply.reply_addr   = 16'(pick) + 16'd1;
                reply.reply_expiry = grant_reg;
            end
        end
        else if (is_req)
        begin
            reply.reply_client = item_reg.client_id;
            reply.reply_addr   = item_reg.requested_addr;
            if (req_ok)
            begin
                reply.reply_kind   = KIND_ACK;
                reply.reply_expiry = grant_reg;
            end
            else
            begin
                reply.reply_kind = KIND_NAK;
            end
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = p_idx_reg;
        wdata = sw_entry;
        if (cmd.clear_run)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end
        else if (p_valid_reg)
        begin
            we = 1'b1;
        end
        else if (cmd.finish)
        begin
            if (is_disc && found)
            begin
                we    = 1'b1;
                waddr = pick;
                wdata = '{status: ST_PENDING, owner: item_reg.client_id, expiry: grant_reg};
            end
            else if (is_req && req_ok)
            begin
                we    = 1'b1;
                waddr = addr_m1[IDX_W-1:0];
                wdata = '{status: ST_OCCUPIED, owner: cap_own_reg, expiry: grant_reg};
            end
            else if (is_rel && pend_f_reg)
            begin
                we    = 1'b1;
                waddr = pend_i_reg;
                wdata = '0;
            end
        end
    end

    assign sts.clear_done = cmd.clear_run && (clr_cnt_reg == IDX_W'(POOL_DEPTH - 1));
    assign sts.sweep_done = cmd.sweep_run && (rd_cnt_reg == n) && !p_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            rd_cnt_reg  <= '0;
            p_valid_reg <= 1'b0;
            own_f_reg   <= 1'b0;
            free_f_reg  <= 1'b0;
            stale_f_reg <= 1'b0;
            pend_f_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_run)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            p_valid_reg <= 1'b0;
            if (cmd.latch)
            begin
                rd_cnt_reg  <= '0;
                own_f_reg   <= 1'b0;
                free_f_reg  <= 1'b0;
                stale_f_reg <= 1'b0;
                pend_f_reg  <= 1'b0;
            end
            else if (cmd.sweep_run && rd_cnt_reg != n)
            begin
                rd_cnt_reg  <= rd_cnt_reg + NW'(1);
                p_valid_reg <= 1'b1;
            end
            if (p_valid_reg)
            begin
                if (!own_f_reg && sw_entry.status != ST_FREE
                    && sw_entry.owner == item_reg.client_id)
                begin
                    own_f_reg <= 1'b1;
                end
                if (!free_f_reg && sw_entry.status == ST_FREE)
                begin
                    free_f_reg <= 1'b1;
                end
                if (!stale_f_reg && sw_entry.status == ST_STALE)
                begin
                    stale_f_reg <= 1'b1;
                end
                if (!pend_f_reg && sw_entry.status == ST_PENDING
                    && sw_entry.owner == item_reg.client_id)
                begin
                    pend_f_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= in_data;
        end
        if (cmd.grant_a)
        begin
            d_reg  <= item_reg.requested_expiry - item_reg.msg_time;
            lt_reg <= item_reg.requested_expiry < item_reg.msg_time;
        end
        if (cmd.grant_b)
        begin
            use_req_reg <= 1'b0;
            if (item_reg.requested_expiry == 32'd0)
            begin
                addend_reg <= default_lease;
            end
            else if (lt_reg || d_reg < min_lease)
            begin
                addend_reg <= min_lease;
            end
            else if (d_reg <= max_lease)
            begin
                addend_reg  <= min_lease;
                use_req_reg <= 1'b1;
            end
            else
            begin
                addend_reg <= max_lease;
            end
        end
        if (cmd.grant_c)
        begin
            // saturate at all ones
            grant_reg <= use_req_reg ? item_reg.requested_expiry
                       : (grant_sum[32] ? 32'hFFFF_FFFF : grant_sum[31:0]);
        end
        p_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        if (p_valid_reg)
        begin
            if (!own_f_reg)
            begin
                own_i_reg <= p_idx_reg;
            end
            if (!free_f_reg)
            begin
                free_i_reg <= p_idx_reg;
            end
            if (!stale_f_reg)
            begin
                stale_i_reg <= p_idx_reg;
            end
            if (!pend_f_reg)
            begin
                pend_i_reg <= p_idx_reg;
            end
        end
        if (cap_hit)
        begin
            cap_st_reg  <= sw_entry.status;
            cap_own_reg <= sw_entry.owner;
        end
        if (cmd.finish)
        begin
            out_reg <= reply;
        end
    end

    assign out_data = out_reg;

`ifndef SYNTHESIS
    a_sweep_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (NW'(p_idx_reg) < n))
        else $error("sweep touched an entry outside the pool");

    a_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> !cmd.finish && !cmd.clear_run)
        else $error("sweep write-back collides with another write");
`endif

endmodule

`default_nettype wire

FILE: rtl/address_lease_server.sv
// Top level of the address lease server: APB register file plus controller
// and datapath. Depends on als_pkg, als_ctrl, als_dpath, als_ram.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------
//  in       | in_valid / in_stall        | in_data  (in_item_t)
//  out      | out_valid / out_stall      | out_data (out_item_t)
//  config   | psel penable pwrite pready | paddr, pwdata, prdata
//
// A message is latched, its lease is clamped in the grant A, B and C states, then one
// pass reads N = min(pool_size, POOL_DEPTH) table entries at one entry per cycle, then
// one finish. After reset a clearing pass zeroes every table entry; in_stall is high.
// A stalled result sits in the output register while the next message is accepted
// and processed; the finish step waits for the output register to drain.
`default_nettype none

module address_lease_server
    import als_pkg::*;
#(
    parameter int POOL_DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [10:0] pool_size_reg;
    logic [31:0] default_lease_reg;
    logic [31:0] max_lease_reg;
    logic [31:0] min_lease_reg;
    logic        wr_en;
    cmd_t        cmd;
    sts_t        sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg     <= 11'd1024;
            default_lease_reg <= 32'd3600;
            max_lease_reg     <= 32'd7200;
            min_lease_reg     <= 32'd60;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_POOL_SIZE:     pool_size_reg     <= pwdata[10:0];
                REG_DEFAULT_LEASE: default_lease_reg <= pwdata;
                REG_MAX_LEASE:     max_lease_reg     <= pwdata;
                REG_MIN_LEASE:     min_lease_reg     <= pwdata;
                default:           pool_size_reg     <= pool_size_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_POOL_SIZE:     prdata = {21'd0, pool_size_reg};
            REG_DEFAULT_LEASE: prdata = default_lease_reg;
            REG_MAX_LEASE:     prdata = max_lease_reg;
            REG_MIN_LEASE:     prdata = min_lease_reg;
            default:           prdata = '0;
        endcase
    end

    als_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    als_dpath #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_data      (in_data),
        .out_data     (out_data),
        .pool_size    (pool_size_reg),
        .default_lease(default_lease_reg),
        .max_lease    (max_lease_reg),
        .min_lease    (min_lease_reg)
    );

endmodule

`default_nettype wire
